// File: hdl/fspr_pkg.sv
// Shared types, constants and the frame check helper for the setpoint ramp link.
// Used by the front end, the command queue, the ramp back end, the top level and the checker.
package fspr_pkg;

	localparam logic [7:0] SYNC_A      = 8'hAA;
	localparam logic [7:0] SYNC_B      = 8'hBB;
	localparam logic [7:0] CMD_STREAM  = 8'h05;
	localparam logic [7:0] FLAG_DATA   = 8'h00;
	localparam logic [7:0] FLAG_EOF    = 8'h01;
	localparam logic [7:0] FLAG_CANCEL = 8'h02;

	localparam logic [7:0] RAMP_STEP_RESET = 8'd2;

	// Depth of the command queue between the front end and the ramp back end (2 or more).
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// Commands passed from the front end to the back end.
	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_START = 2'd1;
	localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic       frame_flag;
		logic [7:0] level;
		logic [7:0] frame_check;
	} out_item_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [7:0]      value;
	} cmd_t;

	// 8-bit sum of the four leading bytes of a frame.
	function automatic logic [7:0] sum8(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic [7:0] d);
		sum8 = a + b + c + d;
	endfunction

endpackage

// File: hdl/framed_setpoint_ramp_link.sv
// Top level of the framed setpoint ramp link: step register, front end, queue, back end.
// Depends on fspr_pkg, fspr_front, fspr_queue and fspr_back.
//
//   Channel   Direction  Handshake            Payload
//   in        sink       in_valid / in_stall  in_data  (kind, rx_byte)
//   out       source     out_valid/out_stall  out_data (frame_flag, level, frame_check)
//   cfg       sink       cfg_wr_en            cfg_wr_data (ramp_step)
//
// While in_stall is low, one input item is taken per cycle; the front end classifies it in
// the cycle of its transfer. A result goes through the command queue to the output register.
// in_stall rises only when the command queue is full; out_stall holds the output register
// and stops the back end, while the queue keeps absorbing input.
// Reset clears all control state and loads a ramp step of 2.
module framed_setpoint_ramp_link #(
	parameter int QUEUE_DEPTH = fspr_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  fspr_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output fspr_pkg::out_item_t out_data,
	input  logic                cfg_wr_en,
	input  logic [7:0]          cfg_wr_data
);
	import fspr_pkg::*;

	logic [7:0] ramp_step_q;
	logic       q_push, q_pop, q_full, q_valid;
	cmd_t       q_cmd, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ramp_step_q <= RAMP_STEP_RESET;
		else if (cfg_wr_en) ramp_step_q <= cfg_wr_data;
	end

	fspr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	fspr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.full     (q_full),
		.valid    (q_valid),
		.head     (q_head)
	);

	fspr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ramp_step (ramp_step_q),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// File: hdl/fspr_front.sv
// Front end: takes input transfers, tracks the frame receiver and classifies each item.
// Depends on fspr_pkg; pushes commands into fspr_queue.
module fspr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  fspr_pkg::in_item_t in_data,
	input  logic              q_full,
	output logic              q_push,
	output fspr_pkg::cmd_t    q_cmd
);
	import fspr_pkg::*;

	localparam logic [2:0] POS_HUNT   = 3'd0;
	localparam logic [2:0] POS_SYNC_A = 3'd1;
	localparam logic [2:0] POS_CMD    = 3'd2;
	localparam logic [2:0] POS_FLAG   = 3'd3;
	localparam logic [2:0] POS_CHECK  = 3'd4;

	logic [2:0] sync_count_q, sync_count_d;
	logic [7:0] cmd_hold_q, flag_hold_q;
	logic       accept;
	logic       is_byte;
	logic [7:0] b;
	logic       frame_ok;

	assign in_stall = q_full;
	assign accept   = in_valid & ~in_stall;
	assign is_byte  = ~in_data.kind;
	assign b        = in_data.rx_byte;

	assign frame_ok = (sync_count_q == POS_CHECK) && (cmd_hold_q == CMD_STREAM) &&
		(b == sum8(SYNC_A, SYNC_B, cmd_hold_q, flag_hold_q));

	always_comb begin
		unique case (sync_count_q)
			POS_SYNC_A: begin
				if (b == SYNC_B) sync_count_d = POS_CMD;
				else if (b == SYNC_A) sync_count_d = POS_SYNC_A;
				else sync_count_d = POS_HUNT;
			end
			POS_CMD:   sync_count_d = POS_FLAG;
			POS_FLAG:  sync_count_d = POS_CHECK;
			POS_CHECK: sync_count_d = POS_HUNT;
			default:   sync_count_d = (b == SYNC_A) ? POS_SYNC_A : POS_HUNT;
		endcase
	end

	// Ticks always go through; a byte yields a command only when it completes a valid frame.
	always_comb begin
		q_push      = 1'b0;
		q_cmd.op    = OP_TICK;
		q_cmd.value = b;
		if (accept) begin
			if (!is_byte) begin
				q_push = 1'b1;
			end else if (frame_ok) begin
				if (flag_hold_q == FLAG_DATA) begin
					q_push   = 1'b1;
					q_cmd.op = OP_START;
				end else if (flag_hold_q == FLAG_EOF || flag_hold_q == FLAG_CANCEL) begin
					q_push   = 1'b1;
					q_cmd.op = OP_STOP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_count_q <= POS_HUNT;
			cmd_hold_q   <= '0;
			flag_hold_q  <= '0;
		end else if (accept && is_byte) begin
			sync_count_q <= sync_count_d;
			if (sync_count_q == POS_CMD) cmd_hold_q <= b;
			if (sync_count_q == POS_FLAG) flag_hold_q <= b;
		end
	end

endmodule

// File: hdl/fspr_queue.sv
// Short command queue between the front end and the ramp back end.
// Depends on fspr_pkg for the command type.
module fspr_queue #(
	parameter int DEPTH = fspr_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fspr_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           valid,
	output fspr_pkg::cmd_t head
);
	import fspr_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop  = pop & valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hdl/fspr_back.sv
// Back end: carries out queued commands, ramps the level and holds the output register.
// Depends on fspr_pkg; reads commands from fspr_queue.
module fspr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         ramp_step,
	input  logic               q_valid,
	input  fspr_pkg::cmd_t     q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output fspr_pkg::out_item_t out_data
);
	import fspr_pkg::*;

	logic [7:0] target_q, level_q;
	logic       streaming_q, ticker_alive_q;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       out_free;
	logic [8:0] up_sum;
	logic [7:0] down_gap;
	logic [7:0] level_next;
	logic       emit_data, emit_eof;

	assign out_free  = ~out_valid_q | ~out_stall;
	assign q_pop     = q_valid & out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// One step toward the target, stopping on it rather than passing it.
	always_comb begin
		up_sum   = {1'b0, level_q} + {1'b0, ramp_step};
		down_gap = level_q - target_q;
		if (level_q < target_q) begin
			level_next = (up_sum > {1'b0, target_q}) ? target_q : up_sum[7:0];
		end else if (level_q > target_q) begin
			level_next = (down_gap >= ramp_step) ? level_q - ramp_step : target_q;
		end else begin
			level_next = level_q;
		end
	end

	assign emit_data = q_pop && (q_head.op == OP_TICK) && ticker_alive_q && streaming_q;
	assign emit_eof  = q_pop && (q_head.op == OP_STOP) && streaming_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q       <= '0;
			level_q        <= '0;
			streaming_q    <= 1'b0;
			ticker_alive_q <= 1'b0;
		end else if (q_pop) begin
			unique case (q_head.op)
				OP_TICK: begin
					if (ticker_alive_q) begin
						if (!streaming_q) ticker_alive_q <= 1'b0;
						else level_q <= level_next;
					end
				end
				OP_START: begin
					target_q <= q_head.value;
					// A stop still draining through the ticker blocks a restart.
					if (!streaming_q && !ticker_alive_q) begin
						streaming_q    <= 1'b1;
						ticker_alive_q <= 1'b1;
					end
				end
				OP_STOP: begin
					streaming_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit_data | emit_eof;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_data) begin
			out_q.frame_flag  <= 1'b0;
			out_q.level       <= level_next;
			out_q.frame_check <= sum8(SYNC_A, SYNC_B, CMD_STREAM, FLAG_DATA);
		end else if (emit_eof) begin
			out_q.frame_flag  <= 1'b1;
			out_q.level       <= '0;
			out_q.frame_check <= sum8(SYNC_A, SYNC_B, CMD_STREAM, FLAG_EOF);
		end
	end

endmodule

// File: hdl/fspr_checker.sv
// Port-level checks for the framed setpoint ramp link, bound to the top level.
// Depends on fspr_pkg and framed_setpoint_ramp_link.
module fspr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input fspr_pkg::out_item_t out_data
);
	import fspr_pkg::*;

	// A stalled result must still be offered, unchanged, on the next cycle.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output transfer dropped or changed while stalled");

	// The check byte always matches the frame kind.
	a_check_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.frame_check ==
			sum8(SYNC_A, SYNC_B, CMD_STREAM, {7'd0, out_data.frame_flag}))
		else $error("frame check byte does not match frame kind");

	// End-of-stream frames carry a zero level.
	a_eof_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_flag |-> out_data.level == 8'd0)
		else $error("end-of-stream frame with non-zero level");

endmodule

bind framed_setpoint_ramp_link fspr_checker u_fspr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// File: tb/sv/framed_setpoint_ramp_link_tb.sv
// Self-checking testbench for framed_setpoint_ramp_link: sends bytes and ticks with random
// gaps and output stalls, predicts every frame from its own copy of the link state and compares.
// Depends on fspr_pkg and the framed_setpoint_ramp_link RTL.
module framed_setpoint_ramp_link_tb;
	import fspr_pkg::*;

	localparam int   RUN_LIMIT  = 400000;
	localparam int   SETTLE     = 40;
	localparam int   IDLE_PCT   = 19;
	localparam int   LONG_HOLD  = 300;
	localparam int   PHASE_SIZE = 470;
	localparam logic KIND_BYTE  = 1'b0;
	localparam logic KIND_TICK  = 1'b1;
	localparam logic FRAME_DATA = 1'b0;
	localparam logic FRAME_EOS  = 1'b1;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_data;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = '0;

	// Predicted state of the link.
	logic [2:0] rx_pos = '0;
	logic [7:0] held_cmd = '0;
	logic [7:0] held_flag = '0;
	logic [7:0] target_lvl = '0;
	logic [7:0] level_now = '0;
	logic       streaming = 1'b0;
	logic       ticker_alive = 1'b0;
	logic [7:0] step_now = RAMP_STEP_RESET;

	in_item_t  events_to_send[$];
	out_item_t frames_owed[$];
	out_item_t owed_frame;
	int        errors = 0;
	int        pushed = 0;
	logic      in_taken = 1'b0;
	logic      next_valid;
	in_item_t  next_item;
	bit        calm = 1'b0;
	bit        hold_req = 1'b0;
	bit        hold_seen = 1'b0;
	int        hold_left = 0;
	logic [7:0] phase_step;

	framed_setpoint_ramp_link i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [7:0] check_of(input logic [7:0] cmd, input logic [7:0] flag);
		check_of = SYNC_A + SYNC_B + cmd + flag;
	endfunction

	task automatic note_mismatch(input string what, input string want, input string got);
		errors++;
		if (errors <= 10)
			$display("mismatch on %s: expected %s, got %s", what, want, got);
	endtask

	// Advances the predicted link by one accepted item and queues any frame it causes.
	task automatic advance_link(input in_item_t it);
		logic [8:0] lvl;
		logic [7:0] b;
		out_item_t  fr;
		b = it.rx_byte;
		if (it.kind == KIND_TICK) begin
			if (ticker_alive && !streaming) begin
				ticker_alive = 1'b0;
			end else if (ticker_alive) begin
				lvl = {1'b0, level_now};
				if (level_now < target_lvl) begin
					lvl = level_now + step_now;
					if (lvl > {1'b0, target_lvl})
						lvl = {1'b0, target_lvl};
				end else if (level_now > target_lvl) begin
					lvl = ({1'b0, level_now} >= target_lvl + step_now) ?
						{1'b0, level_now - step_now} : {1'b0, target_lvl};
				end
				level_now = lvl[7:0];
				fr.frame_flag = FRAME_DATA;
				fr.level = level_now;
				fr.frame_check = check_of(CMD_STREAM, FLAG_DATA);
				frames_owed.push_back(fr);
			end
		end else begin
			case (rx_pos)
				3'd1: begin
					if (b == SYNC_B)
						rx_pos = 3'd2;
					else if (b == SYNC_A)
						rx_pos = 3'd1;
					else
						rx_pos = 3'd0;
				end
				3'd2: begin
					held_cmd = b;
					rx_pos = 3'd3;
				end
				3'd3: begin
					held_flag = b;
					rx_pos = 3'd4;
				end
				3'd4: begin
					rx_pos = 3'd0;
					if (b == check_of(held_cmd, held_flag) && held_cmd == CMD_STREAM) begin
						if (held_flag == FLAG_DATA) begin
							target_lvl = b;
							// A stop that the ticker has not yet seen blocks a restart.
							if (!streaming && !ticker_alive) begin
								streaming = 1'b1;
								ticker_alive = 1'b1;
							end
						end else if ((held_flag == FLAG_EOF || held_flag == FLAG_CANCEL)
								&& streaming) begin
							streaming = 1'b0;
							fr.frame_flag = FRAME_EOS;
							fr.level = 8'd0;
							fr.frame_check = check_of(CMD_STREAM, FLAG_EOF);
							frames_owed.push_back(fr);
						end
					end
				end
				default: rx_pos = (b == SYNC_A) ? 3'd1 : 3'd0;
			endcase
		end
	endtask

	// Monitor: checks each output transfer, then predicts from each input transfer.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (frames_owed.size() == 0) begin
				note_mismatch("unowed frame", "none", $sformatf("%h", out_data));
			end else begin
				owed_frame = frames_owed.pop_front();
				if (out_data.frame_flag !== owed_frame.frame_flag)
					note_mismatch("frame_flag", $sformatf("%0h", owed_frame.frame_flag),
						$sformatf("%0h", out_data.frame_flag));
				if (out_data.level !== owed_frame.level)
					note_mismatch("level", $sformatf("%0h", owed_frame.level),
						$sformatf("%0h", out_data.level));
				if (out_data.frame_check !== owed_frame.frame_check)
					note_mismatch("frame_check", $sformatf("%0h", owed_frame.frame_check),
						$sformatf("%0h", out_data.frame_check));
			end
		end
		if (arst_n && in_valid && !in_stall)
			advance_link(in_data);
		in_taken <= arst_n && in_valid && !in_stall;
	end

	// Sender: holds each item until its transfer, then offers the next after a random gap.
	always @(negedge clk) begin
		next_valid = in_valid;
		next_item = in_data;
		if (in_taken)
			next_valid = 1'b0;
		if (!next_valid && arst_n && events_to_send.size() != 0
				&& (calm || $urandom_range(99) >= IDLE_PCT)) begin
			next_valid = 1'b1;
			next_item = events_to_send.pop_front();
		end
		in_valid <= next_valid;
		in_data <= next_item;
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	always @(negedge clk) begin
		if (hold_left == 0 && hold_req != hold_seen) begin
			hold_left = LONG_HOLD;
			hold_seen = hold_req;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	task automatic push_byte(input logic [7:0] b);
		events_to_send.push_back({KIND_BYTE, b});
		pushed++;
	endtask

	task automatic push_tick();
		logic [7:0] ignored;
		ignored = 8'($urandom_range(255));
		events_to_send.push_back({KIND_TICK, ignored});
		pushed++;
	endtask

	task automatic push_frame(input logic [7:0] cmd, input logic [7:0] flag,
			input logic [7:0] chk);
		push_byte(SYNC_A);
		push_byte(SYNC_B);
		push_byte(cmd);
		push_byte(flag);
		push_byte(chk);
	endtask

	task automatic push_random_chunk();
		int         pick;
		logic [7:0] cmd;
		logic [7:0] flag;
		logic [7:0] chk;
		pick = $urandom_range(99);
		if (pick < 45) begin
			case ($urandom_range(3))
				0: flag = FLAG_DATA;
				1: flag = FLAG_EOF;
				2: flag = FLAG_CANCEL;
				default: flag = 8'($urandom_range(255));
			endcase
			push_frame(CMD_STREAM, flag, check_of(CMD_STREAM, flag));
		end else if (pick < 55) begin
			// Either a foreign command or a stream command whose check byte is corrupted.
			cmd = $urandom_range(1) ? CMD_STREAM : 8'($urandom_range(255));
			flag = $urandom_range(1) ? 8'($urandom_range(2)) : 8'($urandom_range(255));
			chk = check_of(cmd, flag);
			if (cmd == CMD_STREAM || $urandom_range(1))
				chk = chk ^ (8'd1 << $urandom_range(7));
			push_frame(cmd, flag, chk);
		end else if (pick < 85) begin
			repeat ($urandom_range(1, 4)) push_tick();
		end else if (pick < 95) begin
			repeat ($urandom_range(1, 3))
				push_byte($urandom_range(1) ? SYNC_A : 8'($urandom_range(255)));
		end else begin
			// A frame cut short, sometimes with a repeated first sync byte.
			push_byte(SYNC_A);
			if ($urandom_range(1))
				push_byte(SYNC_A);
			push_byte(SYNC_B);
			if ($urandom_range(1))
				push_byte(CMD_STREAM);
		end
	endtask

	task automatic wait_idle();
		while (events_to_send.size() != 0 || in_valid || frames_owed.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_step(input logic [7:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		step_now = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		push_tick();
		push_byte(SYNC_A);
		push_frame(CMD_STREAM, FLAG_DATA, check_of(CMD_STREAM, FLAG_DATA));
		push_tick();
		push_tick();
		push_frame(CMD_STREAM, FLAG_EOF, check_of(CMD_STREAM, FLAG_EOF));
		push_frame(CMD_STREAM, FLAG_DATA, check_of(CMD_STREAM, FLAG_DATA));
		push_tick();
		push_frame(CMD_STREAM, FLAG_CANCEL, check_of(CMD_STREAM, FLAG_CANCEL));
		wait_idle();

		// The output is held off while ticks keep arriving, so the command queue fills.
		write_step(8'd255);
		hold_req = !hold_req;
		push_frame(CMD_STREAM, FLAG_DATA, check_of(CMD_STREAM, FLAG_DATA));
		repeat (30) push_tick();
		wait_idle();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: phase_step = 8'd1;
				2: phase_step = 8'd255;
				default: phase_step = 8'($urandom_range(1, 255));
			endcase
			write_step(phase_step);
			calm = (ph == 0);
			pushed = 0;
			while (pushed < PHASE_SIZE) begin
				push_random_chunk();
				if (ph == 2 && pushed >= PHASE_SIZE / 2 && hold_req == hold_seen
						&& hold_left == 0 && events_to_send.size() < 8)
					hold_req = !hold_req;
				while (events_to_send.size() > 16)
					@(negedge clk);
			end
			wait_idle();
			calm = 1'b0;
		end

		if (errors == 0 && frames_owed.size() == 0)
			$display("framed_setpoint_ramp_link_tb: done, clean");
		else
			$display("framed_setpoint_ramp_link_tb: done, errors");
		$finish;
	end

	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("framed_setpoint_ramp_link_tb: done, errors");
		$finish;
	end

endmodule
